// File: hdl/rdri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdri_pkg: shared constants for the radix digit rotation index block
// Widths, limits and configuration register indexes used by every module.
// ----------------------------------------------------------------------------
package rdri_pkg;

    localparam int INDEX_BITS = 32;
    localparam int MAX_DIGITS = 16;
    localparam int MAX_RADIX  = 16;

    // Register widths of the configuration fields.
    localparam int COUNT_W = 5;
    localparam int RADIX_W = 5;
    localparam int ROT_W   = 4;

    // A power of the radix may reach 2^INDEX_BITS, so it needs one extra bit.
    localparam int WIDE_W = INDEX_BITS + 1;
    localparam int PROD_W = WIDE_W + RADIX_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_AMOUNT = 2'd2;

endpackage

// File: hdl/rdri_mul_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdri_mul_radix: shared multiply-by-radix unit
// Multiplies a wide operand by the configured radix and flags any product
// above 2^INDEX_BITS.
// ----------------------------------------------------------------------------
module rdri_mul_radix
    import rdri_pkg::*;
(
    input  logic [WIDE_W-1:0]  operand,
    input  logic [RADIX_W-1:0] radix,
    output logic [WIDE_W-1:0]  product,
    output logic               overflow
);

    logic [PROD_W-1:0] full;

    assign full    = PROD_W'(operand) * PROD_W'(radix);
    assign product = full[WIDE_W-1:0];

    // Anything above 2^INDEX_BITS does not fit an index space.
    assign overflow = (|full[PROD_W-1:WIDE_W]) ||
                      (full[WIDE_W-1] && (|full[INDEX_BITS-1:0]));

endmodule

// File: hdl/rdri_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdri_div: iterative restoring divider
// Divides an index by a power of the radix, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdri_div
    import rdri_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [INDEX_BITS-1:0] dividend,
    input  logic [WIDE_W-1:0]     divisor,
    output logic                  done,
    output logic [INDEX_BITS-1:0] quotient,
    output logic [WIDE_W-1:0]     remainder
);

    localparam int STEP_W = $clog2(INDEX_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [WIDE_W-1:0]     rem_reg, rem_next;
    logic [INDEX_BITS-1:0] quo_reg, quo_next;
    logic [WIDE_W-1:0]     div_reg, div_next;

    logic [WIDE_W:0]       trial;
    logic [WIDE_W:0]       diff;

    assign trial = {rem_reg, quo_reg[INDEX_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            // The quotient bits shift in where the dividend bits shift out.
            if (!diff[WIDE_W]) begin
                rem_next = diff[WIDE_W-1:0];
                quo_next = {quo_reg[INDEX_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[WIDE_W-1:0];
                quo_next = {quo_reg[INDEX_BITS-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(INDEX_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: hdl/radix_digit_rotation_index_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_rotation_index_top: cyclic qudit shift index permutation
// Maps a destination index of a state vector to its source index under a
// cyclic rotation of the base-radix digits.
// ----------------------------------------------------------------------------
// The block takes one destination index per input transaction and returns one
// source index per output transaction, with range_error on tuser. Writing the
// index as digits d0..d(n-1), most significant first, the result has the digits
// rotated left by s = rotate_amount mod digit_count places, which equals
// (index mod radix^(n-s)) * radix^s + index / radix^(n-s). Each item passes
// through these steps in order: the rotation is reduced by repeated
// subtraction, radix^n and radix^(n-s) are built with one shared
// multiply-by-radix unit, a restoring divider performs the split, and the same
// multiplier then scales the remainder s times. The input is not ready while an
// item is in flight; a finished result sits in the output register, and the next
// transaction is taken while it waits there. The user must write configuration
// through the cfg port only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module radix_digit_rotation_index_top
    import rdri_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [INDEX_BITS-1:0] s_tdata,   // [31:0] dest_index

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [INDEX_BITS-1:0] m_tdata,   // [31:0] source_index
    output logic                  m_tuser    // [0] range_error
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_POWER  = 3'd2;
    localparam logic [2:0] ST_DIVIDE = 3'd3;
    localparam logic [2:0] ST_RECOMB = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    // Configuration registers.
    logic [COUNT_W-1:0]    digit_count_reg;
    logic [RADIX_W-1:0]    radix_reg;
    logic [ROT_W-1:0]      rotate_reg;

    // Sequencer and datapath registers.
    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0]    srot_reg, srot_next;
    logic [COUNT_W-1:0]    cnt_reg, cnt_next;
    logic [WIDE_W-1:0]     pow_reg, pow_next;
    logic [WIDE_W-1:0]     pd_reg, pd_next;
    logic                  ovf_reg, ovf_next;
    logic [WIDE_W-1:0]     acc_reg, acc_next;
    logic [INDEX_BITS-1:0] res_reg, res_next;
    logic                  err_reg, err_next;

    // Output register.
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [INDEX_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic                  cfg_ok;
    logic [COUNT_W-1:0]    n_minus_s;
    logic [WIDE_W-1:0]     mul_operand;
    logic [WIDE_W-1:0]     mul_product;
    logic                  mul_overflow;
    logic                  div_start;
    logic                  div_done;
    logic [INDEX_BITS-1:0] div_quotient;
    logic [WIDE_W-1:0]     div_remainder;
    logic                  in_take;
    logic                  out_free;

    // ------------------------------------------------------------------------
    // Configuration registers. The port is always ready; an index past the
    // register list is dropped.
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= COUNT_W'(1);
            radix_reg       <= RADIX_W'(2);
            rotate_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DIGIT_COUNT:   digit_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_RADIX:         radix_reg       <= cfg_data[RADIX_W-1:0];
                CFG_ROTATE_AMOUNT: rotate_reg      <= cfg_data[ROT_W-1:0];
                default: ;
            endcase
        end
    end

    // A digit count or radix outside its legal range makes every index an error.
    assign cfg_ok = (digit_count_reg >= COUNT_W'(1)) &&
                    (digit_count_reg <= COUNT_W'(MAX_DIGITS)) &&
                    (radix_reg >= RADIX_W'(2)) &&
                    (radix_reg <= RADIX_W'(MAX_RADIX));

    assign n_minus_s = digit_count_reg - srot_reg;

    // ------------------------------------------------------------------------
    // Shared units. The multiplier builds the radix powers in the power phase
    // and scales the remainder in the recombine phase.
    // ------------------------------------------------------------------------
    assign mul_operand = (state_reg == ST_POWER) ? pow_reg : acc_reg;

    rdri_mul_radix u_mul (
        .operand  (mul_operand),
        .radix    (radix_reg),
        .product  (mul_product),
        .overflow (mul_overflow)
    );

    // The divisor is taken from the next value so that a zero rotation, where
    // radix^n is captured in the very cycle the divider starts, is seen too.
    rdri_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (idx_reg),
        .divisor   (pd_next),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        srot_next     = srot_reg;
        cnt_next      = cnt_reg;
        pow_next      = pow_reg;
        pd_next       = pd_reg;
        ovf_next      = ovf_reg;
        acc_next      = acc_reg;
        res_next      = res_reg;
        err_next      = err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    idx_next  = s_tdata;
                    srot_next = {1'b0, rotate_reg};
                    res_next  = '0;
                    if (cfg_ok) begin
                        err_next   = 1'b0;
                        state_next = ST_REDUCE;
                    end else begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_REDUCE: begin
                // Rotation mod digit count by repeated subtraction.
                if (srot_reg >= digit_count_reg) begin
                    srot_next = srot_reg - digit_count_reg;
                end else begin
                    cnt_next   = '0;
                    pow_next   = WIDE_W'(1);
                    ovf_next   = 1'b0;
                    state_next = ST_POWER;
                end
            end
            ST_POWER: begin
                // pow_reg holds radix^cnt; keep radix^(n-s) as the divisor.
                if (cnt_reg == n_minus_s) begin
                    pd_next = pow_reg;
                end
                if (cnt_reg == digit_count_reg) begin
                    if (ovf_reg || ({1'b0, idx_reg} >= pow_reg)) begin
                        err_next   = 1'b1;
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end else begin
                    pow_next = mul_product;
                    ovf_next = ovf_reg || mul_overflow;
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    acc_next   = div_remainder;
                    cnt_next   = '0;
                    state_next = ST_RECOMB;
                end
            end
            ST_RECOMB: begin
                // The low digits move up by s places; the quotient fills in below.
                if (cnt_reg == srot_reg) begin
                    res_next   = acc_reg[INDEX_BITS-1:0] + div_quotient;
                    state_next = ST_FINISH;
                end else begin
                    acc_next = mul_product;
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        srot_reg    <= srot_next;
        cnt_reg     <= cnt_next;
        pow_reg     <= pow_next;
        pd_reg      <= pd_next;
        ovf_reg     <= ovf_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // An error result always carries a zero index.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("range error result with nonzero index");

    // Once an item is taken the block is busy on the following cycle.
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transaction");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    // The multiplier never flags overflow on the remainder scaling.
    a_recomb_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RECOMB) && (cnt_reg != srot_reg)) |-> !mul_overflow)
        else $error("overflow while scaling the remainder");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for radix_digit_rotation_index_top
// Drives destination indexes through the input stream under many register
// settings, predicts each source index and range flag, and checks them in order.
// ----------------------------------------------------------------------------
module testbench;
    import rdri_pkg::*;

    // Clock period is 10 ns; RESET_CYCLES sets how long reset is held.
    localparam int RESET_CYCLES = 8;
    // DRAIN_CYCLES of quiet at the end give any straggler the chance to show up.
    localparam int DRAIN_CYCLES = 300;
    // The slowest correct run stays well under CYCLE_LIMIT even with heavy stalls.
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 60;

    // The register index the block does not implement; writes to it are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] source_index;
        logic                  range_error;
    } source_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the three registers, predicts the
    // result of every accepted index and compares results in arrival order.
    // ------------------------------------------------------------------------
    class index_scoreboard;
        int unsigned    digits_q = 1;
        int unsigned    radix_q = 2;
        int unsigned    rot_q = 0;
        source_result_t expected_sources[$];
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    flagged;

        // Number of entries of the state vector, or 0 when the setting is
        // illegal or the vector does not fit the index width.
        static function longint unsigned vector_size(int unsigned n, int unsigned r);
            longint unsigned p;
            p = 1;
            if (n < 1 || n > MAX_DIGITS || r < 2 || r > MAX_RADIX) return 0;
            for (int i = 0; i < n; i++) begin
                p = p * r;
                if (p > (64'd1 << INDEX_BITS)) return 0;
            end
            return p;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIGIT_COUNT:   digits_q = data;
                CFG_RADIX:         radix_q = data;
                CFG_ROTATE_AMOUNT: rot_q = data[ROT_W-1:0];
                default: ;
            endcase
        endfunction

        // Splits the index into digits, most significant first, and puts digit k
        // back at the weight of position (k - s) mod n.
        function source_result_t rotated_source(logic [INDEX_BITS-1:0] dest);
            source_result_t  res;
            longint unsigned size;
            longint unsigned rem;
            longint unsigned acc;
            longint unsigned weight [MAX_DIGITS];
            longint unsigned digit [MAX_DIGITS];
            int              n;
            int              s;
            res.source_index = '0;
            res.range_error = 1'b1;
            size = vector_size(digits_q, radix_q);
            if (size == 0 || dest >= size) return res;
            n = digits_q;
            weight[n-1] = 1;
            for (int k = n - 1; k > 0; k--) weight[k-1] = weight[k] * radix_q;
            rem = dest;
            for (int k = n - 1; k >= 0; k--) begin
                digit[k] = rem % radix_q;
                rem = rem / radix_q;
            end
            s = rot_q % n;
            acc = 0;
            for (int k = 0; k < n; k++) acc += digit[k] * weight[(k + n - s) % n];
            res.source_index = acc[INDEX_BITS-1:0];
            res.range_error = 1'b0;
            return res;
        endfunction

        function void note_input(logic [INDEX_BITS-1:0] dest);
            expected_sources.insert(expected_sources.size(), rotated_source(dest));
        endfunction

        function void check_result(logic [INDEX_BITS-1:0] src, logic err);
            source_result_t want;
            if (expected_sources.size() == 0) begin
                $error("unexpected result: source_index %h range_error %b", src, err);
                errors++;
                return;
            end
            want = expected_sources.pop_front();
            checked++;
            if (err) flagged++;
            if (src !== want.source_index) begin
                $error("source_index: expected %h, actual %h", want.source_index, src);
                errors++;
            end
            if (err !== want.range_error) begin
                $error("range_error: expected %b, actual %b", want.range_error, err);
                errors++;
            end
        endfunction

        function int pending();
            return expected_sources.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [INDEX_BITS-1:0] s_tdata;   // [31:0] dest_index
    logic                  m_tvalid;
    logic                  m_tready;
    logic [INDEX_BITS-1:0] m_tdata;   // [31:0] source_index
    logic                  m_tuser;   // [0] range_error

    index_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     sent;
    int unsigned     settings;
    int unsigned     cycles;

    radix_digit_rotation_index_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // The receiver decides at every falling edge whether to stall the next
    // cycle, so back-pressure lands on every phase of the block's work.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Results are sampled at the rising edge, where the handshake completes.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog: a hung handshake must not keep the run going forever.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase
    endtask

    // Always waits on a falling edge first, so a valid lowered by the caller
    // is never raised again within the same time step.
    task automatic wait_drained();
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with s_tvalid still high, so back-to-back transactions need no gap.
    task automatic send_index(logic [INDEX_BITS-1:0] dest);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= dest;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(dest);
        sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge aclk);
    endtask

    // Registers are only touched once the block has delivered everything.
    // A write to the unused index can be slipped in to check that it is dropped.
    task automatic configure(int unsigned n, int unsigned r, int unsigned rot, bit junk);
        s_tvalid <= 1'b0;
        wait_drained();
        write_reg(CFG_DIGIT_COUNT, CFG_DATA_W'(n));
        if (junk) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
        write_reg(CFG_RADIX, CFG_DATA_W'(r));
        write_reg(CFG_ROTATE_AMOUNT, CFG_DATA_W'(rot));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Mostly indexes inside the vector, with the boundary and raw 32-bit noise.
    function automatic logic [INDEX_BITS-1:0] pick_index();
        longint unsigned size;
        int unsigned     roll;
        size = index_scoreboard::vector_size(sb.digits_q, sb.radix_q);
        roll = $urandom_range(99);
        if (size != 0 && roll < 70) return INDEX_BITS'({$urandom, $urandom} % size);
        if (size != 0 && roll < 80) return INDEX_BITS'(size - 1);
        if (size != 0 && roll < 86 && size < (64'd1 << INDEX_BITS))
            return INDEX_BITS'(size);
        return $urandom;
    endfunction

    // Picks a register setting: mostly legal vectors with random rotation,
    // some that fill all 32 index bits, some too large, some illegal.
    task automatic random_setting();
        int unsigned roll;
        int unsigned n;
        int unsigned r;
        roll = $urandom_range(99);
        if (roll < 10) begin
            if ($urandom_range(1)) begin
                n = $urandom_range(1) ? 0 : $urandom_range(17, 31);
                r = $urandom_range(2, 16);
            end else begin
                n = $urandom_range(1, 16);
                r = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            end
        end else if (roll < 28) begin
            n = $urandom_range(1) ? 16 : 8;
            r = (n == 16) ? 4 : 16;
        end else if (roll < 36) begin
            n = $urandom_range(11, 16);
            r = $urandom_range(9, 16);
        end else begin
            r = $urandom_range(2, 16);
            n = $urandom_range(1, 16);
            while (index_scoreboard::vector_size(n, r) == 0) n--;
        end
        configure(n, r, $urandom_range(0, 31), $urandom_range(3) == 0);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sent = 0;
        settings = 0;
        cycles = 0;
        sb = new();
        set_idle(IDLE_NONE);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values: one binary digit, so only indexes 0 and 1 are in range.
        send_index(32'd0);
        send_index(32'd1);
        send_index(32'd2);
        send_index(32'hFFFF_FFFF);

        // Sixteen base-4 digits span exactly 2^32, every index is legal,
        // and the largest rotation is applied.
        configure(16, 4, 15, 1'b0);
        send_index(32'd0);
        send_index(32'hFFFF_FFFF);
        send_index(32'h1234_5678);
        send_index(32'h8000_0001);

        // A rotation larger than the digit count must wrap; the fifth data bit
        // of the rotation write is dropped as well (30 becomes 14, 14 mod 3 is 2).
        configure(3, 7, 30, 1'b1);
        send_index(32'd0);
        send_index(32'd342);
        send_index(32'd343);
        send_index(32'd100);

        // 16^16 does not fit the index, so everything is flagged.
        configure(16, 16, 0, 1'b0);
        send_index(32'd0);
        send_index(32'd5);

        // Digit counts and radices outside their legal ranges.
        configure(0, 2, 0, 1'b0);
        send_index(32'd0);
        configure(17, 2, 0, 1'b0);
        send_index(32'd0);
        configure(31, 31, 1, 1'b0);
        send_index(32'd0);
        configure(4, 0, 1, 1'b0);
        send_index(32'd0);
        configure(4, 1, 1, 1'b0);
        send_index(32'd0);
        configure(4, 17, 1, 1'b0);
        send_index(32'd0);

        // Eight hex digits with a rotation of three, unused register poked too.
        configure(8, 16, 3, 1'b1);
        send_index(32'h0000_0001);
        send_index(32'hFEDC_BA98);

        // Random part: each phase gets a fresh setting and cycles through the
        // idle mixes. One phase also holds off the sender halfway through
        // until every outstanding result has been delivered.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_setting();
            set_idle(idle_mode_t'(ph % 4));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 5 && i == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
                send_index(pick_index());
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d destination indexes under %0d register settings and four idle mixes.",
                 sent, settings);
        $display("Checked %0d source indexes, %0d of them flagged out of range.",
                 sb.checked, sb.flagged);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
